>>> design/pcfr_pkg.sv
// Shared types and constants of the POV clock face renderer.
package pcfr_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam int REG_W = 8;
    localparam logic [2:0] REG_POSITION_OFFSET  = 3'd0;
    localparam logic [2:0] REG_VISIBLE_LIMIT    = 3'd1;
    localparam logic [2:0] REG_MINUTE_HALFWIDTH = 3'd2;
    localparam logic [2:0] REG_SECOND_HALFWIDTH = 3'd3;
    localparam logic [2:0] REG_CENTIS_HALFWIDTH = 3'd4;

    localparam logic [REG_W-1:0] RST_POSITION_OFFSET  = 8'd32;
    localparam logic [REG_W-1:0] RST_VISIBLE_LIMIT    = 8'd192;
    localparam logic [REG_W-1:0] RST_MINUTE_HALFWIDTH = 8'd4;
    localparam logic [REG_W-1:0] RST_SECOND_HALFWIDTH = 8'd2;
    localparam logic [REG_W-1:0] RST_CENTIS_HALFWIDTH = 8'd1;

    typedef struct packed {
        logic [REG_W-1:0] position_offset;
        logic [REG_W-1:0] visible_limit;
        logic [REG_W-1:0] minute_halfwidth;
        logic [REG_W-1:0] second_halfwidth;
        logic [REG_W-1:0] centis_halfwidth;
    } t_cfg;

    // Serial divider: one quotient bit per cycle over a 32-bit dividend
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Hand scaling: four hands, four phases each, run while the divider works
    localparam int NUM_HANDS  = 4;
    localparam int HAND_IDX_W = $clog2(NUM_HANDS);
    localparam int HAND_PHASES = 4;
    localparam int HAND_CYCLES = NUM_HANDS * HAND_PHASES;

    localparam logic [HAND_IDX_W-1:0] HAND_CENTIS  = 2'd0;
    localparam logic [HAND_IDX_W-1:0] HAND_SECONDS = 2'd1;
    localparam logic [HAND_IDX_W-1:0] HAND_MINUTES = 2'd2;
    localparam logic [HAND_IDX_W-1:0] HAND_HOURS   = 2'd3;

    typedef enum logic [1:0] {
        HP_SELECT = 2'd0,
        HP_SCALE  = 2'd1,
        HP_RECIP  = 2'd2,
        HP_FIX    = 2'd3
    } t_hand_phase;

    // hand = (V * value) / divisor, via floor(2^shift / divisor) and one fix-up
    localparam logic [15:0] HAND_DIVISOR [NUM_HANDS] = '{16'd100, 16'd60, 16'd60, 16'd12};
    localparam logic [15:0] HAND_RECIP   [NUM_HANDS] = '{16'd41943, 16'd34952, 16'd34952,
                                                         16'd43690};
    localparam logic [4:0]  HAND_SHIFT   [NUM_HANDS] = '{5'd22, 5'd21, 5'd21, 5'd19};

    localparam logic [7:0] HOUR_SPAN = 8'd12;
    localparam logic [7:0] BCD_NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic                  load;
        logic                  div_step;
        logic                  hand_en;
        logic [HAND_IDX_W-1:0] hand_idx;
        t_hand_phase           hand_phase;
        logic                  calc_pos;
        logic                  finish;
    } t_cmd;

    typedef struct packed {
        logic period_zero;
    } t_sts;

endpackage

>>> design/pcfr_regs.sv
// APB configuration register bank of the POV clock face renderer.
module pcfr_regs import pcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [REG_W-1:0] w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.position_offset  <= RST_POSITION_OFFSET;
            r_cfg.visible_limit    <= RST_VISIBLE_LIMIT;
            r_cfg.minute_halfwidth <= RST_MINUTE_HALFWIDTH;
            r_cfg.second_halfwidth <= RST_SECOND_HALFWIDTH;
            r_cfg.centis_halfwidth <= RST_CENTIS_HALFWIDTH;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_POSITION_OFFSET:  r_cfg.position_offset  <= pwdata[REG_W-1:0];
                REG_VISIBLE_LIMIT:    r_cfg.visible_limit    <= pwdata[REG_W-1:0];
                REG_MINUTE_HALFWIDTH: r_cfg.minute_halfwidth <= pwdata[REG_W-1:0];
                REG_SECOND_HALFWIDTH: r_cfg.second_halfwidth <= pwdata[REG_W-1:0];
                REG_CENTIS_HALFWIDTH: r_cfg.centis_halfwidth <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_POSITION_OFFSET:  w_rd = r_cfg.position_offset;
            REG_VISIBLE_LIMIT:    w_rd = r_cfg.visible_limit;
            REG_MINUTE_HALFWIDTH: w_rd = r_cfg.minute_halfwidth;
            REG_SECOND_HALFWIDTH: w_rd = r_cfg.second_halfwidth;
            REG_CENTIS_HALFWIDTH: w_rd = r_cfg.centis_halfwidth;
            default:              w_rd = '0;
        endcase
    end

    assign prdata = {{(32-REG_W){1'b0}}, w_rd};
    assign o_cfg  = r_cfg;

endmodule

>>> design/pcfr_ctrl.sv
// Sequencer of the POV clock face renderer: accept, divide, position, result.
module pcfr_ctrl import pcfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall,
    output logic o_out_valid
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DIVIDE   = 4'b0010,
        ST_POSITION = 4'b0100,
        ST_RESULT   = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_HANDS = CNT_W'(HAND_CYCLES);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic w_out_free;

    assign w_out_free = !(r_out_valid && i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.hand_idx   = r_cnt[HAND_IDX_W+1:2];
        o_cmd.hand_phase = t_hand_phase'(r_cnt[1:0]);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (!i_sts.period_zero) begin
                        n_state = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                o_cmd.hand_en  = (r_cnt < CNT_HANDS);
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_POSITION;
                end
            end
            ST_POSITION: begin
                o_cmd.calc_pos = 1'b1;
                n_state        = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> design/pcfr_dp.sv
// Datapath of the POV clock face renderer: divider, hand scaler, LED logic, time latch.
module pcfr_dp import pcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  logic [15:0] i_elapsed_ticks,
    input  logic [15:0] i_period_ticks,
    input  logic [7:0]  i_bcd_centis,
    input  logic [7:0]  i_bcd_seconds,
    input  logic [7:0]  i_bcd_minutes,
    input  logic [7:0]  i_bcd_hours,
    output t_sts        o_sts,
    output logic        o_led_on,
    output logic [7:0]  o_position,
    output logic        o_in_blind_zone
);

    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        hi = b >> 4;
        return (b & BCD_NIBBLE_MASK) + (hi << 3) + (hi << 1);
    endfunction

    // hours never exceed 165 after decode, so four conditional subtracts suffice
    function automatic logic [7:0] mod_hours(input logic [7:0] h);
        logic [7:0] v;
        v = h;
        for (int k = 3; k >= 0; k--) begin
            if (v >= 8'(HOUR_SPAN << k)) begin
                v = v - 8'(HOUR_SPAN << k);
            end
        end
        return v;
    endfunction

    function automatic logic near_hand(input logic [7:0] hand, input logic [7:0] pos,
                                       input logic [7:0] hw);
        logic [7:0] d;
        d = (hand >= pos) ? (hand - pos) : (pos - hand);
        return d < hw;
    endfunction

    // divider
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_divisor;
    logic [16:0] w_rem_sh;
    logic [16:0] w_rem_diff;
    logic        w_ge;

    // input time bytes
    logic [7:0] r_bcd_centis, r_bcd_seconds, r_bcd_minutes, r_bcd_hours;

    // hand scaler
    logic [7:0]  r_val;
    logic [15:0] r_prod;
    logic [31:0] r_qm;
    logic [7:0]  r_hand [NUM_HANDS];
    logic [7:0]  w_sel;
    logic [15:0] w_q0;
    logic [15:0] w_fix;

    // position and state
    logic [23:0] w_scaled;
    logic [7:0]  r_pos;
    logic        r_flag;
    logic [7:0]  r_lat_hours, r_lat_minutes, r_lat_seconds, r_lat_centis;
    logic        w_blind, w_fill, w_led;
    logic [7:0]  w_hh;

    logic        r_led;
    logic [7:0]  r_pos_out;
    logic        r_blind;

    assign o_sts.period_zero = (i_period_ticks == 16'd0);

    assign w_rem_sh   = {r_rem, r_quo[31]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_divisor};
    assign w_ge       = (w_rem_sh >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo         <= {i_elapsed_ticks, 16'h0000};
            r_rem         <= '0;
            r_divisor     <= i_period_ticks;
            r_bcd_centis  <= i_bcd_centis;
            r_bcd_seconds <= i_bcd_seconds;
            r_bcd_minutes <= i_bcd_minutes;
            r_bcd_hours   <= i_bcd_hours;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[30:0], w_ge};
            r_rem <= w_ge ? w_rem_diff[15:0] : w_rem_sh[15:0];
        end
    end

    always_comb begin
        case (i_cmd.hand_idx)
            HAND_CENTIS:  w_sel = r_lat_centis;
            HAND_SECONDS: w_sel = r_lat_seconds;
            HAND_MINUTES: w_sel = r_lat_minutes;
            default:      w_sel = mod_hours(r_lat_hours);
        endcase
    end

    assign w_q0  = 16'(r_qm >> HAND_SHIFT[i_cmd.hand_idx]);
    assign w_fix = r_prod - 16'(w_q0 * HAND_DIVISOR[i_cmd.hand_idx]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.hand_en) begin
            unique case (i_cmd.hand_phase)
                HP_SELECT: r_val  <= w_sel;
                HP_SCALE:  r_prod <= 16'(i_cfg.visible_limit) * 16'(r_val);
                HP_RECIP:  r_qm   <= r_prod * HAND_RECIP[i_cmd.hand_idx];
                HP_FIX:    r_hand[i_cmd.hand_idx] <=
                               8'(w_q0 + 16'(w_fix >= HAND_DIVISOR[i_cmd.hand_idx]));
                default: ;
            endcase
        end
    end

    // bits [23:16] of frac * 255 = (frac << 8) - frac
    assign w_scaled = {r_quo[15:0], 8'h00} - r_quo[23:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_pos) begin
            r_pos <= 8'd0 - (w_scaled[23:16] + i_cfg.position_offset);
        end
    end

    assign w_blind = (r_pos >= i_cfg.visible_limit);
    assign w_hh    = r_hand[HAND_HOURS];
    assign w_fill  = (r_lat_hours < HOUR_SPAN) ? (r_pos < w_hh) : (r_pos > w_hh);
    assign w_led   = !w_blind &&
                     (w_fill
                      ^ near_hand(r_hand[HAND_MINUTES], r_pos, i_cfg.minute_halfwidth)
                      ^ near_hand(r_hand[HAND_SECONDS], r_pos, i_cfg.second_halfwidth)
                      ^ near_hand(r_hand[HAND_CENTIS],  r_pos, i_cfg.centis_halfwidth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag        <= 1'b0;
            r_lat_hours   <= '0;
            r_lat_minutes <= '0;
            r_lat_seconds <= '0;
            r_lat_centis  <= '0;
        end else if (i_cmd.finish) begin
            if (w_blind) begin
                if (!r_flag) begin
                    r_flag        <= 1'b1;
                    r_lat_centis  <= bcd_decode(r_bcd_centis);
                    r_lat_seconds <= bcd_decode(r_bcd_seconds);
                    r_lat_minutes <= bcd_decode(r_bcd_minutes);
                    r_lat_hours   <= bcd_decode(r_bcd_hours);
                end
            end else begin
                r_flag <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_led     <= w_led;
            r_pos_out <= r_pos;
            r_blind   <= w_blind;
        end
    end

    assign o_led_on        = r_led;
    assign o_position      = r_pos_out;
    assign o_in_blind_zone = r_blind;

endmodule

>>> design/pov_clock_face_renderer.sv
// Top level of the POV clock face renderer: register bank, sequencer and datapath.
//
//   channel   direction   handshake                  payload
//   input     in          i_in_valid / o_in_stall    ticks, period, four BCD time bytes
//   output    out         o_out_valid / i_out_stall  led_on, position, in_blind_zone
//   config    in          APB psel/penable/pwrite    five 8-bit registers at 4*index
//
// A sample with a nonzero period is not followed by another until it has passed the
// 32-step restoring divider, the position step and the result step; its result is
// registered in the result step. The hand scaler runs beside the divider.
// A sample with a zero period is dropped in its acceptance cycle.
// Reset is synchronous and active low; it restores the register defaults and
// clears the time latch. A stalled result holds in the output register while
// the next sample is divided; only the final load waits for the output to free.
module pov_clock_face_renderer import pcfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_elapsed_ticks,
    input  logic [15:0] i_period_ticks,
    input  logic [7:0]  i_bcd_centis,
    input  logic [7:0]  i_bcd_seconds,
    input  logic [7:0]  i_bcd_minutes,
    input  logic [7:0]  i_bcd_hours,
    // output transaction
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_led_on,
    output logic [7:0]  o_position,
    output logic        o_in_blind_zone,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // hold configuration; the user must write it only while the block is idle, which the block does not enforce
    pcfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // advance one sample through divide, position and result steps
    pcfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // divide, scale the hands, compute the LED bit and latch the time
    pcfr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_period_ticks  (i_period_ticks),
        .i_bcd_centis    (i_bcd_centis),
        .i_bcd_seconds   (i_bcd_seconds),
        .i_bcd_minutes   (i_bcd_minutes),
        .i_bcd_hours     (i_bcd_hours),
        .o_sts           (w_sts),
        .o_led_on        (o_led_on),
        .o_position      (o_position),
        .o_in_blind_zone (o_in_blind_zone)
    );

endmodule

>>> design/pcfr_checker.sv
// Port-level checker of the POV clock face renderer and its bind.
module pcfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [15:0] i_period_ticks,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_led_on,
    input logic        o_in_blind_zone
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_period_ticks != 16'd0) |=> o_in_stall)
        else $error("block took no time for a sample with a known period");

    a_zero_period_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_period_ticks == 16'd0) |=> !o_in_stall)
        else $error("zero-period sample left the block busy");

    a_blind_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_blind_zone |-> !o_led_on)
        else $error("LED lit in the blind zone");

endmodule

bind pov_clock_face_renderer pcfr_checker u_pcfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_period_ticks  (i_period_ticks),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_led_on        (o_led_on),
    .o_in_blind_zone (o_in_blind_zone)
);

>>> tb/pov_clock_face_renderer_test.sv
// Self-checking testbench for the POV clock face renderer: predictor, scoreboard and stimulus.
module pov_clock_face_renderer_test;
    import pcfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD    = 4;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    // a result is registered after the divide, position and result steps; leave a margin
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned SEGMENT_ITEMS = 75;
    localparam int unsigned SETTINGS_PER_PHASE = 6;
    localparam int unsigned PRINT_CAP     = 40;

    typedef struct packed {
        logic [15:0] ticks;
        logic [15:0] period;
        logic [7:0]  centis;
        logic [7:0]  seconds;
        logic [7:0]  minutes;
        logic [7:0]  hours;
    } t_face_sample;

    typedef struct packed {
        logic       led_on;
        logic [7:0] position;
        logic       in_blind_zone;
    } t_face_result;

    // one line of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        t_face_sample smp;
        logic         typed;
        t_face_result want;
    } t_face_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_elapsed_ticks;
    logic [15:0] i_period_ticks;
    logic [7:0]  i_bcd_centis;
    logic [7:0]  i_bcd_seconds;
    logic [7:0]  i_bcd_minutes;
    logic [7:0]  i_bcd_hours;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_led_on;
    logic [7:0]  o_position;
    logic        o_in_blind_zone;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers and of the time latch
    t_cfg        face_cfg;
    bit          time_latched;
    logic [7:0]  held_centis;
    logic [7:0]  held_seconds;
    logic [7:0]  held_minutes;
    logic [7:0]  held_hours;

    t_face_result pending_faces[$];
    t_face_row    directed_rows[$];
    int unsigned  miss_count;
    int unsigned  cycle_count;

    // idle rates in percent for the sending and the receiving side
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    // state of the current simulated rotation
    int unsigned  rot_period;
    int unsigned  rot_steps;
    int unsigned  rot_k;
    int unsigned  rot_left;
    logic [7:0]   rot_centis;
    logic [7:0]   rot_seconds;
    logic [7:0]   rot_minutes;
    logic [7:0]   rot_hours;

    pov_clock_face_renderer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_period_ticks  (i_period_ticks),
        .i_bcd_centis    (i_bcd_centis),
        .i_bcd_seconds   (i_bcd_seconds),
        .i_bcd_minutes   (i_bcd_minutes),
        .i_bcd_hours     (i_bcd_hours),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_led_on        (o_led_on),
        .o_position      (o_position),
        .o_in_blind_zone (o_in_blind_zone),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pov_clock_face_renderer verification failed");
        $finish;
    end

    // Receiver side: stall at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (miss_count < PRINT_CAP) begin
            $display("MISMATCH at %0t: %s: got %0d, want %0d", $time, what, got, want);
        end
        miss_count++;
    endtask

    // --- predictor -----------------------------------------------------------

    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        // a non-BCD nibble simply counts with weight one or ten
        return {4'd0, b[3:0]} + b[7:4] * 8'd10;
    endfunction

    function automatic logic [7:0] hand_angle(input logic [7:0] value, input int unsigned units);
        int unsigned full;
        full = int'(face_cfg.visible_limit) * int'(value) / units;
        return full[7:0];   // a hand past full scale wraps
    endfunction

    function automatic bit hand_hit(input logic [7:0] hand, input logic [7:0] pos,
                                    input logic [7:0] halfwidth);
        int diff;
        diff = int'(hand) - int'(pos);
        if (diff < 0) begin
            diff = -diff;
        end
        return diff < int'(halfwidth);
    endfunction

    // Work out the LED bit for one sample; return 0 when the sample gives no result.
    function automatic bit render_face(input t_face_sample s, output t_face_result r);
        logic [31:0] frac;
        logic [31:0] spun;
        logic [7:0]  angle_sum;
        logic [7:0]  ch, sh, mh, hh;
        bit          fill;
        r = '0;
        if (s.period == 16'd0) begin
            return 1'b0;
        end
        frac = {s.ticks, 16'h0000} / {16'h0000, s.period};
        spun = frac * 32'd255;
        angle_sum = spun[23:16] + face_cfg.position_offset;
        r.position = 8'd0 - angle_sum;
        r.in_blind_zone = (r.position >= face_cfg.visible_limit);
        if (r.in_blind_zone) begin
            // latch only on the first blind sample after the visible part
            if (!time_latched) begin
                time_latched = 1'b1;
                held_centis  = bcd_value(s.centis);
                held_seconds = bcd_value(s.seconds);
                held_minutes = bcd_value(s.minutes);
                held_hours   = bcd_value(s.hours);
            end
        end else begin
            ch = hand_angle(held_centis, 100);
            sh = hand_angle(held_seconds, 60);
            mh = hand_angle(held_minutes, 60);
            hh = hand_angle(held_hours % 8'd12, 12);
            // AM fills up to the hour hand, PM fills beyond it
            fill = (held_hours < 8'd12) ? (r.position < hh) : (r.position > hh);
            time_latched = 1'b0;
            r.led_on = fill ^ hand_hit(mh, r.position, face_cfg.minute_halfwidth)
                            ^ hand_hit(sh, r.position, face_cfg.second_halfwidth)
                            ^ hand_hit(ch, r.position, face_cfg.centis_halfwidth);
        end
        return 1'b1;
    endfunction

    // --- scoreboard ----------------------------------------------------------

    // Sample at the falling edge: a result seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_face_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_faces.size() == 0) begin
                report_mismatch("result with nothing pending, position", o_position, 0);
            end else begin
                want = pending_faces.pop_front();
                if (o_led_on !== want.led_on) begin
                    report_mismatch("led_on", o_led_on, want.led_on);
                end
                if (o_position !== want.position) begin
                    report_mismatch("position", o_position, want.position);
                end
                if (o_in_blind_zone !== want.in_blind_zone) begin
                    report_mismatch("in_blind_zone", o_in_blind_zone, want.in_blind_zone);
                end
            end
        end
    end

    // --- configuration port ---------------------------------------------------

    // Issue one setup and one access phase; leave psel up for a following write.
    task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
        bit ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            @(posedge i_clk);
        end while (!ready);
        case (idx)
            REG_POSITION_OFFSET:  face_cfg.position_offset  = value;
            REG_VISIBLE_LIMIT:    face_cfg.visible_limit    = value;
            REG_MINUTE_HALFWIDTH: face_cfg.minute_halfwidth = value;
            REG_SECOND_HALFWIDTH: face_cfg.second_halfwidth = value;
            REG_CENTIS_HALFWIDTH: face_cfg.centis_halfwidth = value;
            default: ;
        endcase
    endtask

    task automatic program_setting(input t_cfg c);
        write_register(REG_POSITION_OFFSET,  c.position_offset);
        write_register(REG_VISIBLE_LIMIT,    c.visible_limit);
        write_register(REG_MINUTE_HALFWIDTH, c.minute_halfwidth);
        write_register(REG_SECOND_HALFWIDTH, c.second_halfwidth);
        write_register(REG_CENTIS_HALFWIDTH, c.centis_halfwidth);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // First settings of each phase are the extremes, then the defaults, then random.
    function automatic t_cfg pick_setting(input int unsigned k);
        t_cfg c;
        case (k)
            0: begin
                c.position_offset  = 8'd0;
                c.visible_limit    = 8'd255;
                c.minute_halfwidth = 8'd255;
                c.second_halfwidth = 8'd255;
                c.centis_halfwidth = 8'd255;
            end
            1: begin
                c.position_offset  = 8'd255;
                c.visible_limit    = 8'd1;
                c.minute_halfwidth = 8'd0;
                c.second_halfwidth = 8'd0;
                c.centis_halfwidth = 8'd0;
            end
            2: begin
                c.position_offset  = RST_POSITION_OFFSET;
                c.visible_limit    = RST_VISIBLE_LIMIT;
                c.minute_halfwidth = RST_MINUTE_HALFWIDTH;
                c.second_halfwidth = RST_SECOND_HALFWIDTH;
                c.centis_halfwidth = RST_CENTIS_HALFWIDTH;
            end
            default: begin
                c.position_offset  = 8'($urandom_range(255));
                c.visible_limit    = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                                              : 8'($urandom_range(100, 255));
                c.minute_halfwidth = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                              : 8'($urandom_range(12));
                c.second_halfwidth = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                              : 8'($urandom_range(8));
                c.centis_halfwidth = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                              : 8'($urandom_range(4));
            end
        endcase
        return c;
    endfunction

    // --- input side -----------------------------------------------------------

    // Drive one transaction and hold it until taken, then record what it should give.
    task automatic send_sample(input t_face_sample s, input logic typed,
                               input t_face_result typed_want);
        t_face_result r;
        bit           took;
        bit           drain;
        bit           gap;
        drain = ($urandom_range(199) == 0);
        gap   = ($urandom_range(99) < send_idle_pct);
        if (drain || gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            // now and then hold off until the block has emptied
            while (drain && pending_faces.size() != 0) begin
                @(posedge i_clk);
            end
            while ($urandom_range(99) < send_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_in_valid      <= 1'b1;
        i_elapsed_ticks <= s.ticks;
        i_period_ticks  <= s.period;
        i_bcd_centis    <= s.centis;
        i_bcd_seconds   <= s.seconds;
        i_bcd_minutes   <= s.minutes;
        i_bcd_hours     <= s.hours;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        if (render_face(s, r)) begin
            pending_faces.push_back(typed ? typed_want : r);
        end
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet.
    task automatic drain_results();
        int unsigned waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_faces.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_faces.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_faces.size());
            pending_faces.delete();
        end
    endtask

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task automatic add_row(input logic [15:0] ticks, input logic [15:0] period,
                           input logic [7:0] c, input logic [7:0] sec,
                           input logic [7:0] m, input logic [7:0] h,
                           input logic typed, input logic led,
                           input logic [7:0] pos, input logic blind);
        t_face_row row;
        row.smp  = {ticks, period, c, sec, m, h};
        row.typed = typed;
        row.want = {led, pos, blind};
        directed_rows.push_back(row);
    endtask

    // Mostly sweep whole rotations with a held time; mix in noise, jumps and zero periods.
    function automatic t_face_sample next_random_sample();
        t_face_sample s;
        int unsigned  roll;
        int unsigned  ticks;
        roll = $urandom_range(99);
        s.ticks   = 16'($urandom);
        s.period  = 16'($urandom);
        s.centis  = 8'($urandom);
        s.seconds = 8'($urandom);
        s.minutes = 8'($urandom);
        s.hours   = 8'($urandom);
        if (roll < 4) begin
            s.period = 16'd0;
            return s;
        end
        if (roll < 12) begin
            return s;
        end
        if (rot_left == 0) begin
            case ($urandom_range(3))
                0:       rot_period = $urandom_range(1, 16);
                1:       rot_period = $urandom_range(17, 4000);
                2:       rot_period = $urandom_range(4001, 65535);
                default: rot_period = $urandom_range(200, 1000);
            endcase
            rot_steps = $urandom_range(6, 40);
            rot_k     = 0;
            rot_left  = rot_steps;
            if ($urandom_range(9) == 0) begin
                rot_centis  = 8'($urandom);
                rot_seconds = 8'($urandom);
                rot_minutes = 8'($urandom);
                rot_hours   = 8'($urandom);
            end else begin
                rot_centis  = to_bcd($urandom_range(99));
                rot_seconds = to_bcd($urandom_range(59));
                rot_minutes = to_bcd($urandom_range(59));
                rot_hours   = to_bcd($urandom_range(23));
            end
        end
        ticks = rot_k * rot_period / rot_steps;
        if ($urandom_range(9) == 0) begin
            ticks += $urandom_range(rot_period);   // broken sweep: jump ahead
        end
        s.ticks   = 16'(ticks);
        s.period  = 16'(rot_period);
        s.centis  = ($urandom_range(4) == 0) ? to_bcd($urandom_range(99)) : rot_centis;
        s.seconds = rot_seconds;
        s.minutes = rot_minutes;
        s.hours   = rot_hours;
        rot_k++;
        rot_left--;
        return s;
    endfunction

    task automatic run_random_segment(input int unsigned count);
        int unsigned  sent;
        t_face_sample smp;
        sent = 0;
        while (sent < count) begin
            smp = next_random_sample();
            send_sample(smp, 1'b0, '0);
            // zero periods are dropped by the block and do not count
            if (smp.period != 16'd0) begin
                sent++;
            end
        end
    endtask

    // --- main sequence --------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_elapsed_ticks <= '0;
        i_period_ticks  <= '0;
        i_bcd_centis    <= '0;
        i_bcd_seconds   <= '0;
        i_bcd_minutes   <= '0;
        i_bcd_hours     <= '0;
        i_out_stall     <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cycle_count     = 0;
        miss_count      = 0;
        rot_left        = 0;
        send_idle_pct   = 14;
        recv_stall_pct  = 61;

        face_cfg.position_offset  = RST_POSITION_OFFSET;
        face_cfg.visible_limit    = RST_VISIBLE_LIMIT;
        face_cfg.minute_halfwidth = RST_MINUTE_HALFWIDTH;
        face_cfg.second_halfwidth = RST_SECOND_HALFWIDTH;
        face_cfg.centis_halfwidth = RST_CENTIS_HALFWIDTH;
        time_latched = 1'b0;
        held_centis  = '0;
        held_seconds = '0;
        held_minutes = '0;
        held_hours   = '0;

        // Directed table, run with the reset settings. Typed results follow from
        // the offset of 32 alone: a zero tick count lands at position 224, blind.
        //      ticks     period    cs     sec    min    hr     typed led pos  blind
        add_row(16'h0000, 16'h0001, 8'h78, 8'h56, 8'h34, 8'h12, 1, 0, 224, 1); // latch
        add_row(16'h0000, 16'h0000, 8'h11, 8'h22, 8'h33, 8'h44, 0, 0, 0,   0); // no period
        add_row(16'hFFFF, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 223, 1); // still blind
        add_row(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 225, 1);
        add_row(16'h0040, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0); // visible
        add_row(16'h0080, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h00C0, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h00E0, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h0000, 16'h0001, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 224, 1); // non-BCD
        add_row(16'h0000, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0,   0);
        add_row(16'h0040, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0); // hands wrap
        add_row(16'h0060, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h00A0, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h00E0, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h0000, 16'h0001, 8'h00, 8'h59, 8'h59, 8'h23, 1, 0, 224, 1); // PM time
        add_row(16'h0000, 16'h0001, 8'h99, 8'h00, 8'h00, 8'h11, 1, 0, 224, 1); // no relatch
        add_row(16'h0050, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h00B0, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h0001, 16'hFFFF, 8'h45, 8'h30, 8'h15, 8'h08, 0, 0, 0,   0);
        add_row(16'h0000, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 224, 1);
        add_row(16'h0090, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'hFFFF, 16'h0002, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);
        add_row(16'h1234, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0,   0);

        // Hold reset, then release it for good.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            send_sample(directed_rows[n].smp, directed_rows[n].typed, directed_rows[n].want);
        end
        drain_results();

        // Three idling phases: sender light and receiver heavy, the reverse, then none.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 61;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 14;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int k = 0; k < SETTINGS_PER_PHASE; k++) begin
                program_setting(pick_setting(k));
                run_random_segment(SEGMENT_ITEMS);
                drain_results();
            end
        end

        if (miss_count == 0) begin
            $display("pov_clock_face_renderer verification clean");
        end else begin
            $display("pov_clock_face_renderer verification failed");
        end
        $finish;
    end

endmodule
